### design/tbma_pkg.sv
// ----------------------------------------------------------------------------
// tbma_pkg
// Shared constants, codes, command and status types for the tagged buffer
// memory with atomics.
// ----------------------------------------------------------------------------
package tbma_pkg;

  localparam int SLOT_BITS   = 4;
  localparam int OFFSET_BITS = 11;
  localparam int SPACE_BITS  = 4;

  localparam int ADDR_W        = 18;
  localparam int TAG_W         = SPACE_BITS + SLOT_BITS + OFFSET_BITS;
  localparam int EXT_W         = (TAG_W > ADDR_W) ? TAG_W : ADDR_W;
  localparam int NUM_SLOTS     = 1 << SLOT_BITS;
  localparam int MAX_SIZE      = 1 << OFFSET_BITS;
  localparam int SIZE_W        = OFFSET_BITS + 1;
  localparam int LANE_BITS     = 3;
  localparam int ROW_BITS      = OFFSET_BITS - LANE_BITS;
  localparam int BANK_ROW_BITS = ROW_BITS - 1;
  localparam int BANK_ADDR_W   = SLOT_BITS + BANK_ROW_BITS;
  localparam int BANK_DEPTH    = 1 << BANK_ADDR_W;
  localparam int COUNT_W       = SLOT_BITS + 1;
  localparam int DATA_W        = 64;
  localparam int LIVE_W        = 15;
  localparam int ALLOC_W       = 12;
  localparam int STATUS_W      = 3;
  localparam int MODE_W        = 3;
  localparam int OP_W          = 4;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ATOMIC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CMPXCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd5;

  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_AND  = 4'd1;
  localparam logic [OP_W-1:0] OP_DEC  = 4'd2;
  localparam logic [OP_W-1:0] OP_INC  = 4'd3;
  localparam logic [OP_W-1:0] OP_MAX  = 4'd4;
  localparam logic [OP_W-1:0] OP_MIN  = 4'd5;
  localparam logic [OP_W-1:0] OP_OR   = 4'd6;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd7;
  localparam logic [OP_W-1:0] OP_XCHG = 4'd8;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_ALLOC,
    S_ZERO,
    S_FREE
  } state_t;

  typedef struct packed {
    logic accept;
    logic access;
    logic alloc;
    logic zero;
    logic free;
    logic load_res;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic alloc_got;
    logic sweep_last;
  } dp_status_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wcode);
    logic [DATA_W-1:0] m;
    case (wcode)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] sign_bit(input logic [1:0] wcode);
    logic [DATA_W-1:0] b;
    case (wcode)
      2'd0:    b = 64'h0000_0000_0000_0080;
      2'd1:    b = 64'h0000_0000_0000_8000;
      2'd2:    b = 64'h0000_0000_8000_0000;
      default: b = 64'h8000_0000_0000_0000;
    endcase
    return b;
  endfunction

endpackage

### design/tbma_ctrl.sv
// ----------------------------------------------------------------------------
// tbma_ctrl
// Controller state machine: sequences accesses, allocation with its zeroing
// sweep, and free, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module tbma_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tbma_pkg::MODE_W-1:0] mode,
  input  tbma_pkg::dp_status_t        dp_status,
  output tbma_pkg::dp_cmd_t           dp_cmd,
  output logic                        busy
);

  tbma_pkg::state_t state;
  tbma_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbma_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tbma_pkg::S_IDLE: begin
        if (start) begin
          if (mode == tbma_pkg::MODE_ALLOC) begin
            state_next = tbma_pkg::S_ALLOC;
          end else if (mode == tbma_pkg::MODE_FREE) begin
            state_next = tbma_pkg::S_FREE;
          end else begin
            state_next = tbma_pkg::S_ACCESS;
          end
        end
      end
      tbma_pkg::S_ACCESS: state_next = tbma_pkg::S_IDLE;
      tbma_pkg::S_FREE:   state_next = tbma_pkg::S_IDLE;
      tbma_pkg::S_ALLOC: begin
        state_next = dp_status.alloc_got ? tbma_pkg::S_ZERO : tbma_pkg::S_IDLE;
      end
      tbma_pkg::S_ZERO: begin
        if (dp_status.sweep_last) begin
          state_next = tbma_pkg::S_IDLE;
        end
      end
      default: state_next = tbma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd = '0;
    busy   = 1'b1;
    case (state)
      tbma_pkg::S_IDLE: begin
        busy          = 1'b0;
        dp_cmd.accept = start;
      end
      tbma_pkg::S_ACCESS: begin
        dp_cmd.access   = 1'b1;
        dp_cmd.load_res = 1'b1;
        dp_cmd.emit     = 1'b1;
      end
      tbma_pkg::S_FREE: begin
        dp_cmd.free     = 1'b1;
        dp_cmd.load_res = 1'b1;
        dp_cmd.emit     = 1'b1;
      end
      tbma_pkg::S_ALLOC: begin
        dp_cmd.alloc    = 1'b1;
        dp_cmd.load_res = 1'b1;
        dp_cmd.emit     = !dp_status.alloc_got;
      end
      tbma_pkg::S_ZERO: begin
        dp_cmd.zero = 1'b1;
        dp_cmd.emit = dp_status.sweep_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_access_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == tbma_pkg::S_ACCESS |=> state == tbma_pkg::S_IDLE)
    else $error("access did not finish in one cycle");
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.emit |-> busy)
    else $error("result emitted while idle");
  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state == tbma_pkg::S_ZERO && !dp_status.sweep_last) |=> state == tbma_pkg::S_ZERO)
    else $error("zeroing sweep left early");
`endif

endmodule

### design/tbma_datapath.sv
// ----------------------------------------------------------------------------
// tbma_datapath
// Word memory, slot tables, free slot FIFO, atomic ALU and result registers.
// ----------------------------------------------------------------------------
module tbma_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tbma_pkg::dp_cmd_t              dp_cmd,
  output tbma_pkg::dp_status_t           dp_status,
  input  logic                           cfg_we,
  input  logic [tbma_pkg::SPACE_BITS-1:0] cfg_wdata,
  input  logic [tbma_pkg::MODE_W-1:0]    mode,
  input  logic [tbma_pkg::OP_W-1:0]      atomic_op,
  input  logic [1:0]                     width_code,
  input  logic                           signed_compare,
  input  logic [tbma_pkg::ADDR_W-1:0]    address,
  input  logic [tbma_pkg::DATA_W-1:0]    operand,
  input  logic [tbma_pkg::DATA_W-1:0]    compare_value,
  input  logic [tbma_pkg::ALLOC_W-1:0]   alloc_size,
  output logic                           done,
  output logic [tbma_pkg::STATUS_W-1:0]  status,
  output logic [tbma_pkg::DATA_W-1:0]    read_value,
  output logic [tbma_pkg::ADDR_W-1:0]    new_address,
  output logic [tbma_pkg::LIVE_W-1:0]    total_allocated
);

  localparam int SB = tbma_pkg::SLOT_BITS;
  localparam int OB = tbma_pkg::OFFSET_BITS;

  // Even rows of each slot live in one bank and odd rows in the other, so an
  // access that spans two neighboring words reads and writes both at once.
  logic [tbma_pkg::DATA_W-1:0]      mem_even [tbma_pkg::BANK_DEPTH];
  logic [tbma_pkg::DATA_W-1:0]      mem_odd  [tbma_pkg::BANK_DEPTH];
  logic [tbma_pkg::DATA_W-1:0]      rdata_even;
  logic [tbma_pkg::DATA_W-1:0]      rdata_odd;

  logic [tbma_pkg::SPACE_BITS-1:0]  space_id;
  logic [tbma_pkg::NUM_SLOTS-1:0]   slot_valid;
  logic [tbma_pkg::SIZE_W-1:0]      slot_size [tbma_pkg::NUM_SLOTS];
  logic [SB-1:0]                    free_fifo [tbma_pkg::NUM_SLOTS];
  logic [SB-1:0]                    free_head;
  logic [tbma_pkg::COUNT_W-1:0]     free_count;
  logic [tbma_pkg::COUNT_W-1:0]     next_fresh;
  logic [tbma_pkg::LIVE_W-1:0]      live_bytes;
  logic [tbma_pkg::LIVE_W-1:0]      live_next;

  logic [tbma_pkg::MODE_W-1:0]      mode_q;
  logic [tbma_pkg::OP_W-1:0]        op_q;
  logic [1:0]                       wcode_q;
  logic                             sgn_q;
  logic [tbma_pkg::ADDR_W-1:0]      addr_q;
  logic [tbma_pkg::DATA_W-1:0]      val_q;
  logic [tbma_pkg::DATA_W-1:0]      cmp_q;
  logic [tbma_pkg::ALLOC_W-1:0]     size_q;

  logic [SB-1:0]                    zslot;
  logic [tbma_pkg::BANK_ROW_BITS-1:0] zrow;

  logic [tbma_pkg::EXT_W-1:0]       ext_in;
  logic [tbma_pkg::EXT_W-1:0]       ext_q;
  logic [SB-1:0]                    slot_in;
  logic [tbma_pkg::ROW_BITS-1:0]    row_in;
  logic [tbma_pkg::BANK_ROW_BITS-1:0] even_row_in;
  logic [tbma_pkg::SPACE_BITS-1:0]  space_f;
  logic [SB-1:0]                    slot_f;
  logic [OB-1:0]                    off_f;
  logic [tbma_pkg::ROW_BITS-1:0]    row_q;
  logic [tbma_pkg::BANK_ROW_BITS-1:0] even_row_q;
  logic [5:0]                       shamt;
  logic [tbma_pkg::DATA_W-1:0]      mask_q;
  logic [tbma_pkg::DATA_W-1:0]      flip;
  logic [2*tbma_pkg::DATA_W-1:0]    pair;
  logic [2*tbma_pkg::DATA_W-1:0]    pair_mask;
  logic [2*tbma_pkg::DATA_W-1:0]    pair_new;
  logic [tbma_pkg::DATA_W-1:0]      old;
  logic [tbma_pkg::DATA_W-1:0]      nv;
  logic [3:0]                       nbytes;
  logic [tbma_pkg::SIZE_W:0]        end_off;
  logic                             ok;
  logic                             is_access;
  logic                             wr_access;
  logic                             lt_old_val;
  logic                             lt_val_old;

  logic                             too_big;
  logic                             got_free;
  logic                             got_fresh;
  logic                             alloc_got;
  logic [SB-1:0]                    alloc_slot;
  logic                             bad_free;
  logic [tbma_pkg::TAG_W-1:0]       tag;

  logic                             mem_we;
  logic [tbma_pkg::BANK_ADDR_W-1:0] even_waddr;
  logic [tbma_pkg::BANK_ADDR_W-1:0] odd_waddr;
  logic [tbma_pkg::DATA_W-1:0]      even_wdata;
  logic [tbma_pkg::DATA_W-1:0]      odd_wdata;

  logic [tbma_pkg::STATUS_W-1:0]    res_status;
  logic [tbma_pkg::DATA_W-1:0]      res_rd;
  logic [tbma_pkg::ADDR_W-1:0]      res_naddr;

  assign ext_in      = tbma_pkg::EXT_W'(address);
  assign slot_in     = ext_in[OB +: SB];
  assign row_in      = ext_in[OB-1:tbma_pkg::LANE_BITS];
  assign even_row_in = row_in[tbma_pkg::ROW_BITS-1:1] + tbma_pkg::BANK_ROW_BITS'(row_in[0]);
  assign ext_q   = tbma_pkg::EXT_W'(addr_q);
  assign space_f = ext_q[tbma_pkg::TAG_W-1 -: tbma_pkg::SPACE_BITS];
  assign slot_f  = ext_q[OB +: SB];
  assign off_f   = ext_q[OB-1:0];
  assign row_q      = off_f[OB-1:tbma_pkg::LANE_BITS];
  assign even_row_q = row_q[tbma_pkg::ROW_BITS-1:1] + tbma_pkg::BANK_ROW_BITS'(row_q[0]);
  assign shamt   = {off_f[tbma_pkg::LANE_BITS-1:0], 3'b000};
  assign mask_q  = tbma_pkg::width_mask(wcode_q);
  assign flip    = sgn_q ? tbma_pkg::sign_bit(wcode_q) : '0;
  assign nbytes  = 4'd1 << wcode_q;
  assign end_off = (tbma_pkg::SIZE_W+1)'(off_f) + (tbma_pkg::SIZE_W+1)'(nbytes);
  assign ok      = (space_f == space_id) && (slot_f != '0) && slot_valid[slot_f] &&
                   (end_off <= {1'b0, slot_size[slot_f]});
  assign pair    = row_q[0] ? {rdata_even, rdata_odd} : {rdata_odd, rdata_even};
  assign old     = tbma_pkg::DATA_W'(pair >> shamt) & mask_q;
  assign is_access = (mode_q == tbma_pkg::MODE_LOAD) || (mode_q == tbma_pkg::MODE_STORE) ||
                     (mode_q == tbma_pkg::MODE_ATOMIC) || (mode_q == tbma_pkg::MODE_CMPXCH);
  assign lt_old_val = (old ^ flip) < (val_q ^ flip);
  assign lt_val_old = (val_q ^ flip) < (old ^ flip);

  always_comb begin
    nv = old;
    if (mode_q == tbma_pkg::MODE_ATOMIC) begin
      case (op_q)
        tbma_pkg::OP_ADD:  nv = old + val_q;
        tbma_pkg::OP_AND:  nv = old & val_q;
        tbma_pkg::OP_DEC:  nv = old - 64'd1;
        tbma_pkg::OP_INC:  nv = old + 64'd1;
        tbma_pkg::OP_MAX:  nv = lt_old_val ? val_q : old;
        tbma_pkg::OP_MIN:  nv = lt_val_old ? val_q : old;
        tbma_pkg::OP_OR:   nv = old | val_q;
        tbma_pkg::OP_SUB:  nv = old - val_q;
        tbma_pkg::OP_XCHG: nv = val_q;
        tbma_pkg::OP_XOR:  nv = old ^ val_q;
        default:           nv = old;
      endcase
    end else begin
      nv = val_q;
    end
  end

  assign wr_access = dp_cmd.access && ok &&
                     ((mode_q == tbma_pkg::MODE_STORE) || (mode_q == tbma_pkg::MODE_ATOMIC) ||
                      ((mode_q == tbma_pkg::MODE_CMPXCH) && (old == cmp_q)));

  assign too_big    = 32'(size_q) > 32'(tbma_pkg::MAX_SIZE);
  assign got_free   = free_count != '0;
  assign got_fresh  = next_fresh < tbma_pkg::COUNT_W'(tbma_pkg::NUM_SLOTS - 1);
  assign alloc_got  = !too_big && (got_free || got_fresh);
  assign alloc_slot = got_free ? free_fifo[free_head] : next_fresh[SB-1:0];
  assign bad_free   = (slot_f == '0) || !slot_valid[slot_f];
  assign tag        = {space_id, alloc_slot, {OB{1'b0}}};

  assign dp_status.alloc_got  = alloc_got;
  assign dp_status.sweep_last = (zrow == '1);

  assign pair_mask = {{tbma_pkg::DATA_W{1'b0}}, mask_q} << shamt;
  assign pair_new  = (pair & ~pair_mask) |
                     ({{tbma_pkg::DATA_W{1'b0}}, nv & mask_q} << shamt);

  always_comb begin
    mem_we = wr_access || dp_cmd.zero;
    if (dp_cmd.zero) begin
      even_waddr = {zslot, zrow};
      odd_waddr  = {zslot, zrow};
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      even_waddr = {slot_f, even_row_q};
      odd_waddr  = {slot_f, row_q[tbma_pkg::ROW_BITS-1:1]};
      even_wdata = row_q[0] ? pair_new[2*tbma_pkg::DATA_W-1:tbma_pkg::DATA_W] :
                              pair_new[tbma_pkg::DATA_W-1:0];
      odd_wdata  = row_q[0] ? pair_new[tbma_pkg::DATA_W-1:0] :
                              pair_new[2*tbma_pkg::DATA_W-1:tbma_pkg::DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_even[even_waddr] <= even_wdata;
      mem_odd[odd_waddr]   <= odd_wdata;
    end
    if (dp_cmd.accept) begin
      rdata_even <= mem_even[{slot_in, even_row_in}];
      rdata_odd  <= mem_odd[{slot_in, row_in[tbma_pkg::ROW_BITS-1:1]}];
    end
  end

  always_comb begin
    live_next  = live_bytes;
    res_status = tbma_pkg::ST_OK;
    res_rd     = '0;
    res_naddr  = '0;
    if (dp_cmd.access) begin
      if (is_access) begin
        res_status = ok ? tbma_pkg::ST_OK : tbma_pkg::ST_INVALID;
        if (ok && (mode_q != tbma_pkg::MODE_STORE)) begin
          res_rd = old;
        end
      end
    end else if (dp_cmd.alloc) begin
      if (too_big) begin
        res_status = tbma_pkg::ST_TOO_BIG;
      end else if (!alloc_got) begin
        res_status = tbma_pkg::ST_NO_SLOT;
      end else begin
        live_next = live_bytes + tbma_pkg::LIVE_W'(size_q);
        res_naddr = tbma_pkg::ADDR_W'(tag);
      end
    end else if (dp_cmd.free) begin
      if (bad_free) begin
        res_status = tbma_pkg::ST_BAD_FREE;
      end else begin
        live_next = live_bytes - tbma_pkg::LIVE_W'(slot_size[slot_f]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      mode_q  <= mode;
      op_q    <= atomic_op;
      wcode_q <= width_code;
      sgn_q   <= signed_compare;
      addr_q  <= address;
      val_q   <= operand & tbma_pkg::width_mask(width_code);
      cmp_q   <= compare_value & tbma_pkg::width_mask(width_code);
      size_q  <= alloc_size;
    end
    if (dp_cmd.alloc) begin
      zslot <= alloc_slot;
      zrow  <= '0;
    end else if (dp_cmd.zero) begin
      zrow <= zrow + 1'b1;
    end
    if (dp_cmd.free && !bad_free) begin
      free_fifo[free_head + free_count[SB-1:0]] <= slot_f;
    end
    if (dp_cmd.load_res) begin
      status          <= res_status;
      read_value      <= res_rd;
      new_address     <= res_naddr;
      total_allocated <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_id   <= '0;
      slot_valid <= '0;
      for (int i = 0; i < tbma_pkg::NUM_SLOTS; i++) begin
        slot_size[i] <= '0;
      end
      free_head  <= '0;
      free_count <= '0;
      next_fresh <= tbma_pkg::COUNT_W'(1);
      live_bytes <= '0;
      done       <= 1'b0;
    end else begin
      done       <= dp_cmd.emit;
      live_bytes <= live_next;
      if (cfg_we) begin
        space_id <= cfg_wdata;
      end
      if (dp_cmd.alloc && alloc_got) begin
        slot_valid[alloc_slot] <= 1'b1;
        slot_size[alloc_slot]  <= tbma_pkg::SIZE_W'(size_q);
        if (got_free) begin
          free_head  <= free_head + 1'b1;
          free_count <= free_count - 1'b1;
        end else begin
          next_fresh <= next_fresh + 1'b1;
        end
      end
      if (dp_cmd.free && !bad_free) begin
        slot_valid[slot_f] <= 1'b0;
        slot_size[slot_f]  <= '0;
        free_count         <= free_count + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= tbma_pkg::COUNT_W'(tbma_pkg::NUM_SLOTS))
    else $error("free slot FIFO overflow");
  a_slot0_never_valid: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.alloc && alloc_got |-> alloc_slot != '0)
    else $error("null slot handed out");
  a_zero_slot: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.zero |-> zslot != '0)
    else $error("zeroing sweep on the null slot");
`endif

endmodule

### design/tagged_buffer_memory_atomics.sv
// ----------------------------------------------------------------------------
// tagged_buffer_memory_atomics
// Slot-based buffer memory with allocate, free, load, store and atomics.
// ----------------------------------------------------------------------------
// Usage: drive the item fields and raise start; the item is taken at a clock
// edge where start is high and busy is low. Each item yields one result beat
// on status, read_value, new_address and total_allocated, marked by done for
// exactly one cycle. The receiver cannot stall; results must be taken as they
// appear.
// Load, store, atomic and compare-exchange read the addressed word and its
// neighbor from the even and odd row banks on accept and write them back in
// the next cycle. Free, unused modes and a failed allocation also pass
// through a single busy state. A successful allocation then runs a sweep that
// zeroes the slot's 256 words two per cycle. A new item can be accepted in
// the cycle done is high. The address space register is written through
// cfg_we and cfg_wdata; the user must do so only while the block is idle,
// which the block does not enforce. Synchronous reset empties the slot
// tables, the free slot FIFO and the byte counter, not the data memory.
// ----------------------------------------------------------------------------
module tagged_buffer_memory_atomics (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [tbma_pkg::MODE_W-1:0]     mode,
  input  logic [tbma_pkg::OP_W-1:0]       atomic_op,
  input  logic [1:0]                      width_code,
  input  logic                            signed_compare,
  input  logic [tbma_pkg::ADDR_W-1:0]     address,
  input  logic [tbma_pkg::DATA_W-1:0]     operand,
  input  logic [tbma_pkg::DATA_W-1:0]     compare_value,
  input  logic [tbma_pkg::ALLOC_W-1:0]    alloc_size,
  input  logic                            cfg_we,
  input  logic [tbma_pkg::SPACE_BITS-1:0] cfg_wdata,
  output logic                            done,
  output logic [tbma_pkg::STATUS_W-1:0]   status,
  output logic [tbma_pkg::DATA_W-1:0]     read_value,
  output logic [tbma_pkg::ADDR_W-1:0]     new_address,
  output logic [tbma_pkg::LIVE_W-1:0]     total_allocated
);

  tbma_pkg::dp_cmd_t    dp_cmd;
  tbma_pkg::dp_status_t dp_status;

  tbma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  tbma_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .dp_status       (dp_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mode            (mode),
    .atomic_op       (atomic_op),
    .width_code      (width_code),
    .signed_compare  (signed_compare),
    .address         (address),
    .operand         (operand),
    .compare_value   (compare_value),
    .alloc_size      (alloc_size),
    .done            (done),
    .status          (status),
    .read_value      (read_value),
    .new_address     (new_address),
    .total_allocated (total_allocated)
  );

endmodule

### test/tagged_buffer_memory_atomics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_buffer_memory_atomics_checker
// Watches the command and result channels of the buffer memory, keeps its own
// model of slots, free list, byte counter and data bytes, and compares every
// result beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tagged_buffer_memory_atomics_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [tbma_pkg::MODE_W-1:0]     mode,
  input  logic [tbma_pkg::OP_W-1:0]       atomic_op,
  input  logic [1:0]                      width_code,
  input  logic                            signed_compare,
  input  logic [tbma_pkg::ADDR_W-1:0]     address,
  input  logic [tbma_pkg::DATA_W-1:0]     operand,
  input  logic [tbma_pkg::DATA_W-1:0]     compare_value,
  input  logic [tbma_pkg::ALLOC_W-1:0]    alloc_size,
  input  logic                            cfg_we,
  input  logic [tbma_pkg::SPACE_BITS-1:0] cfg_wdata,
  input  logic                            done,
  input  logic [tbma_pkg::STATUS_W-1:0]   status,
  input  logic [tbma_pkg::DATA_W-1:0]     read_value,
  input  logic [tbma_pkg::ADDR_W-1:0]     new_address,
  input  logic [tbma_pkg::LIVE_W-1:0]     total_allocated,
  output int                              failures,
  output int                              pending
);

  typedef struct packed {
    logic [tbma_pkg::STATUS_W-1:0] st;
    logic [tbma_pkg::DATA_W-1:0]   rd;
    logic [tbma_pkg::ADDR_W-1:0]   na;
    logic [tbma_pkg::LIVE_W-1:0]   live;
  } answer_t;

  answer_t answers[$];

  logic [tbma_pkg::SPACE_BITS-1:0] space_id;
  logic                            valid_q[tbma_pkg::NUM_SLOTS];
  int unsigned                     size_q[tbma_pkg::NUM_SLOTS];
  logic [7:0]                      bytes_q[tbma_pkg::NUM_SLOTS*tbma_pkg::MAX_SIZE];
  int unsigned                     fifo_q[tbma_pkg::NUM_SLOTS];
  int unsigned                     head_q, count_q, fresh_q;
  logic [tbma_pkg::LIVE_W-1:0]     live_q;

  function automatic logic below(logic [63:0] a, logic [63:0] b, logic [1:0] w, logic sgn);
    logic [63:0] flip;
    flip = sgn ? tbma_pkg::sign_bit(w) : 64'd0;
    return (a ^ flip) < (b ^ flip);
  endfunction

  function automatic answer_t predict_beat();
    answer_t     r;
    int unsigned nb, slot, off, sp, base;
    logic [63:0] m, val, cmp, old, nv;
    r = '0;
    nb = 1 << width_code;
    m = tbma_pkg::width_mask(width_code);
    val = operand & m;
    cmp = compare_value & m;
    sp = 32'(address) >> (tbma_pkg::SLOT_BITS + tbma_pkg::OFFSET_BITS);
    slot = (32'(address) >> tbma_pkg::OFFSET_BITS) & (tbma_pkg::NUM_SLOTS - 1);
    off = 32'(address) & (tbma_pkg::MAX_SIZE - 1);
    base = slot * tbma_pkg::MAX_SIZE + off;
    if (mode <= tbma_pkg::MODE_CMPXCH) begin
      if (sp != space_id || slot == 0 || !valid_q[slot] || off + nb > size_q[slot]) begin
        r.st = tbma_pkg::ST_INVALID;
      end else begin
        old = '0;
        for (int i = 0; i < nb; i++) old |= 64'(bytes_q[base+i]) << (8 * i);
        nv = old;
        case (mode)
          tbma_pkg::MODE_STORE: nv = val;
          tbma_pkg::MODE_ATOMIC: begin
            case (atomic_op)
              tbma_pkg::OP_ADD:  nv = old + val;
              tbma_pkg::OP_AND:  nv = old & val;
              tbma_pkg::OP_DEC:  nv = old - 1;
              tbma_pkg::OP_INC:  nv = old + 1;
              tbma_pkg::OP_MAX:  nv = below(old, val, width_code, signed_compare) ? val : old;
              tbma_pkg::OP_MIN:  nv = below(val, old, width_code, signed_compare) ? val : old;
              tbma_pkg::OP_OR:   nv = old | val;
              tbma_pkg::OP_SUB:  nv = old - val;
              tbma_pkg::OP_XCHG: nv = val;
              tbma_pkg::OP_XOR:  nv = old ^ val;
              default:           nv = old;
            endcase
            r.rd = old;
          end
          tbma_pkg::MODE_CMPXCH: begin
            if (old == cmp) nv = val;
            r.rd = old;
          end
          default: r.rd = old;
        endcase
        nv &= m;
        for (int i = 0; i < nb; i++) bytes_q[base+i] = nv[8*i +: 8];
      end
    end else if (mode == tbma_pkg::MODE_ALLOC) begin
      slot = 0;
      if (alloc_size > tbma_pkg::MAX_SIZE) begin
        r.st = tbma_pkg::ST_TOO_BIG;
      end else if (count_q > 0) begin
        slot = fifo_q[head_q];
        head_q = (head_q + 1) % tbma_pkg::NUM_SLOTS;
        count_q--;
      end else if (fresh_q < tbma_pkg::NUM_SLOTS - 1) begin
        slot = fresh_q;
        fresh_q++;
      end else begin
        r.st = tbma_pkg::ST_NO_SLOT;
      end
      if (slot != 0) begin
        valid_q[slot] = 1'b1;
        size_q[slot] = alloc_size;
        for (int i = 0; i < tbma_pkg::MAX_SIZE; i++)
          bytes_q[slot*tbma_pkg::MAX_SIZE+i] = 8'd0;
        live_q = live_q + tbma_pkg::LIVE_W'(alloc_size);
        r.na = tbma_pkg::ADDR_W'((32'(space_id) << (tbma_pkg::SLOT_BITS + tbma_pkg::OFFSET_BITS)) |
                                 (slot << tbma_pkg::OFFSET_BITS));
      end
    end else if (mode == tbma_pkg::MODE_FREE) begin
      if (slot == 0 || !valid_q[slot]) begin
        r.st = tbma_pkg::ST_BAD_FREE;
      end else begin
        live_q = live_q - tbma_pkg::LIVE_W'(size_q[slot]);
        fifo_q[(head_q + count_q) % tbma_pkg::NUM_SLOTS] = slot;
        count_q++;
        valid_q[slot] = 1'b0;
        size_q[slot] = 0;
      end
    end
    r.live = live_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      answers.delete();
      failures = 0;
      space_id = '0;
      for (int i = 0; i < tbma_pkg::NUM_SLOTS; i++) begin
        valid_q[i] = 1'b0;
        size_q[i] = 0;
        fifo_q[i] = 0;
      end
      head_q = 0;
      count_q = 0;
      fresh_q = 1;
      live_q = '0;
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          report_mismatch("unexpected beat", 64'(status), 64'd0);
        end else begin
          e = answers.pop_front();
          if (status !== e.st) report_mismatch("status", 64'(status), 64'(e.st));
          if (read_value !== e.rd) report_mismatch("read_value", read_value, e.rd);
          if (new_address !== e.na)
            report_mismatch("new_address", 64'(new_address), 64'(e.na));
          if (total_allocated !== e.live)
            report_mismatch("total_allocated", 64'(total_allocated), 64'(e.live));
        end
      end
      if (cfg_we) space_id = cfg_wdata;
      if (start && !busy) answers.insert(answers.size(), predict_beat());
    end
    pending = answers.size();
  end

endmodule

### test/tagged_buffer_memory_atomics_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_buffer_memory_atomics_test
// Drives directed and random allocate, free, load, store, atomic and
// compare-exchange commands under several address space settings, with
// random sender gaps, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tagged_buffer_memory_atomics_test;

  logic                            clk, rst, start, busy, cfg_we, done, signed_compare;
  logic [tbma_pkg::MODE_W-1:0]     mode;
  logic [tbma_pkg::OP_W-1:0]       atomic_op;
  logic [1:0]                      width_code;
  logic [tbma_pkg::ADDR_W-1:0]     address;
  logic [tbma_pkg::DATA_W-1:0]     operand, compare_value, read_value;
  logic [tbma_pkg::ALLOC_W-1:0]    alloc_size;
  logic [tbma_pkg::SPACE_BITS-1:0] cfg_wdata;
  logic [tbma_pkg::STATUS_W-1:0]   status;
  logic [tbma_pkg::ADDR_W-1:0]     new_address;
  logic [tbma_pkg::LIVE_W-1:0]     total_allocated;
  int                              failures, pending, gap_pct, cycles;
  logic [tbma_pkg::ADDR_W-1:0]     live_addrs[$];

  tagged_buffer_memory_atomics u_top (.*);
  tagged_buffer_memory_atomics_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("** tagged_buffer_memory_atomics: FAILED **");
        $finish;
      end
    end
  end

  task automatic send(logic [tbma_pkg::MODE_W-1:0] md, logic [tbma_pkg::OP_W-1:0] op,
                      logic [1:0] w, logic sg, logic [tbma_pkg::ADDR_W-1:0] ad,
                      logic [63:0] opnd, logic [63:0] cmp,
                      logic [tbma_pkg::ALLOC_W-1:0] sz);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    mode <= md; atomic_op <= op; width_code <= w; signed_compare <= sg;
    address <= ad; operand <= opnd; compare_value <= cmp; alloc_size <= sz;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_space(logic [tbma_pkg::SPACE_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2: v = 64'h80 << (8 * $urandom_range(7));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [tbma_pkg::ADDR_W-1:0] pick_addr(logic [1:0] w);
    logic [tbma_pkg::ADDR_W-1:0] a;
    int unsigned                 off;
    if (live_addrs.size() == 0 || $urandom_range(9) == 0) return tbma_pkg::ADDR_W'($urandom);
    a = live_addrs[$urandom_range(live_addrs.size() - 1)];
    off = $urandom_range(15) << w;
    if ($urandom_range(7) == 0) off = $urandom_range(tbma_pkg::MAX_SIZE - 1) & ~((1 << w) - 1);
    return a | tbma_pkg::ADDR_W'(off);
  endfunction

  task automatic random_item();
    logic [1:0]                  w;
    logic [tbma_pkg::ADDR_W-1:0] a;
    int unsigned                 k, sz;
    w = 2'($urandom);
    k = $urandom_range(99);
    if (k < 6) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(64);
      if ($urandom_range(15) == 0) sz = tbma_pkg::MAX_SIZE;
      send(tbma_pkg::MODE_ALLOC, '0, w, 1'b0, '0, '0, '0, tbma_pkg::ALLOC_W'(sz));
    end else if (k < 10) begin
      if (live_addrs.size() != 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
      end else begin
        a = tbma_pkg::ADDR_W'($urandom);
      end
      send(tbma_pkg::MODE_FREE, '0, w, 1'b0, a, '0, '0, '0);
    end else begin
      k = $urandom_range(99);
      send(k < 25 ? tbma_pkg::MODE_LOAD : k < 50 ? tbma_pkg::MODE_STORE :
           k < 85 ? tbma_pkg::MODE_ATOMIC : k < 97 ? tbma_pkg::MODE_CMPXCH :
           tbma_pkg::MODE_W'($urandom_range(6, 7)),
           tbma_pkg::OP_W'($urandom_range(15)), w, 1'($urandom), pick_addr(w), rnd64(),
           ($urandom_range(1) ? '0 : rnd64()), tbma_pkg::ALLOC_W'($urandom));
    end
  endtask

  // Allocations are tracked by watching the result beat for a fresh address.
  always @(posedge clk) begin
    if (!rst && done && status == tbma_pkg::ST_OK && new_address != '0)
      live_addrs.insert(live_addrs.size(), new_address);
  end

  initial begin
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    mode = '0; atomic_op = '0; width_code = '0; signed_compare = 1'b0;
    address = '0; operand = '0; compare_value = '0; alloc_size = '0; gap_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_space(4'd3);
    send(tbma_pkg::MODE_LOAD, tbma_pkg::OP_ADD, 2'd3, 1'b0, 18'h0, '0, '0, '0);
    send(tbma_pkg::MODE_ALLOC, tbma_pkg::OP_ADD, 2'd0, 1'b0, '0, '0, '0, 12'd4095);
    send(tbma_pkg::MODE_ALLOC, tbma_pkg::OP_ADD, 2'd0, 1'b0, '0, '0, '0, 12'd2048);
    send(tbma_pkg::MODE_ALLOC, tbma_pkg::OP_ADD, 2'd0, 1'b0, '0, '0, '0, 12'd0);
    send(tbma_pkg::MODE_ALLOC, tbma_pkg::OP_ADD, 2'd0, 1'b0, '0, '0, '0, 12'd16);
    drain();
    begin
      logic [tbma_pkg::ADDR_W-1:0] big;
      big = live_addrs[0];
      send(tbma_pkg::MODE_STORE, tbma_pkg::OP_ADD, 2'd3, 1'b0, big | 18'd2040, '1, '0, '0);
      send(tbma_pkg::MODE_LOAD, tbma_pkg::OP_ADD, 2'd3, 1'b0, big | 18'd2041, '0, '0, '0);
      send(tbma_pkg::MODE_LOAD, tbma_pkg::OP_ADD, 2'd0, 1'b0, big | 18'd2047, '0, '0, '0);
      for (int op = 0; op < 16; op++)
        send(tbma_pkg::MODE_ATOMIC, tbma_pkg::OP_W'(op), 2'(op), op[0], big | 18'd8,
             64'h8000_0000_0000_0081, '0, '0);
      send(tbma_pkg::MODE_CMPXCH, tbma_pkg::OP_ADD, 2'd2, 1'b0, big, 64'h1234, '0, '0);
      send(tbma_pkg::MODE_CMPXCH, tbma_pkg::OP_ADD, 2'd2, 1'b0, big, 64'h5678, '0, '0);
      send(3'd6, tbma_pkg::OP_ADD, 2'd0, 1'b0, big, '1, '1, '1);
      send(3'd7, tbma_pkg::OP_ADD, 2'd0, 1'b0, big, '1, '1, '1);
      send(tbma_pkg::MODE_LOAD, tbma_pkg::OP_ADD, 2'd0, 1'b0, live_addrs[1], '0, '0, '0);
      send(tbma_pkg::MODE_FREE, tbma_pkg::OP_ADD, 2'd0, 1'b0, 18'h0, '0, '0, '0);
    end
    for (int i = 0; i < 16; i++)
      send(tbma_pkg::MODE_ALLOC, tbma_pkg::OP_ADD, 2'd0, 1'b0, '0, '0, '0, 12'd8);
    drain();
    while (live_addrs.size() > 4) begin
      send(tbma_pkg::MODE_FREE, tbma_pkg::OP_ADD, 2'd0, 1'b0, live_addrs[0], '0, '0, '0);
      live_addrs.pop_front();
    end
    for (int phase = 0; phase < 6; phase++) begin
      gap_pct = phase < 2 ? 16 : phase < 4 ? 48 : 0;
      if (phase == 1) set_space(4'd15);
      if (phase == 2) set_space(4'd0);
      if (phase == 3) set_space(4'd7);
      if (phase == 4) set_space(4'd9);
      if (phase == 5) set_space(4'd5);
      repeat (185) random_item();
    end
    drain();
    if (failures == 0) begin
      $display("** tagged_buffer_memory_atomics: PASSED **");
    end else begin
      $display("** tagged_buffer_memory_atomics: FAILED **");
    end
    $finish;
  end

endmodule

### tagged_buffer_memory_atomics.f
design/tbma_pkg.sv
design/tbma_ctrl.sv
design/tbma_datapath.sv
design/tagged_buffer_memory_atomics.sv
test/tagged_buffer_memory_atomics_checker.sv
test/tagged_buffer_memory_atomics_test.sv
